// File: rtl/ugcbp_pkg.sv
// Shared types and codes for the uniform grid collision broad phase.
// No dependencies; the front end, back end and top level import this package.
`timescale 1ns / 1ps
`default_nettype none
package ugcbp_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_OUTSIDE   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_CANDIDATE = 3'd3;
  localparam logic [2:0] ST_NONE      = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  localparam logic [2:0] CFG_CELL_SIZE = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_X  = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd2;
  localparam logic [2:0] CFG_GRID_COLS = 3'd3;
  localparam logic [2:0] CFG_GRID_ROWS = 3'd4;

  typedef struct packed {
    logic [30:0] cell_size;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [6:0]  grid_cols;
    logic [6:0]  grid_rows;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/ugcbp_fifo.sv
// Two-entry queue between the classifying front end and the grid back end.
// Depends on nothing but its WIDTH parameter.
`timescale 1ns / 1ps
`default_nettype none
module ugcbp_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && !empty) rptr <= ~rptr;
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slot[wptr] <= wdata;
  end

endmodule
`default_nettype wire

// File: rtl/ugcbp_front.sv
// Front end: accepts commands, floor-divides both coordinates by the cell size
// with a shared bit-serial divider pass, and queues classified requests. Uses ugcbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ugcbp_front
  import ugcbp_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  parameter int CW = 8,
  parameter int RW = 8,
  parameter int QW = 2 + 10 + CW + RW
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [1:0]          req_type,
  input  wire logic [9:0]          ball_id,
  input  wire logic signed [31:0]  pos_x,
  input  wire logic signed [31:0]  pos_y,
  input  wire cfg_t                cfg,
  output logic                     busy,
  output logic                     q_push,
  output logic [QW-1:0]            q_data,
  input  wire logic                q_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t     state;
  logic [1:0]  req;
  logic [9:0]  id;
  logic        negx, negy;
  logic [30:0] ds;
  logic [31:0] remx, remy;
  logic [32:0] quox, quoy;
  logic [5:0]  cnt;

  logic signed [32:0] lx, ly;
  logic [64:0]        stepx, stepy;
  logic signed [34:0] fx, fy;
  logic signed [CW-1:0] col_c;
  logic signed [RW-1:0] row_c;

  // One restoring step: shift one dividend bit into the partial remainder.
  function automatic logic [64:0] div_step(input logic [31:0] rem, input logic [32:0] quo,
                                           input logic [30:0] d);
    logic [31:0] t;
    logic        b;
    t = {rem[30:0], quo[32]};
    b = (t >= {1'b0, d});
    if (b) t = t - {1'b0, d};
    return {t, quo[31:0], b};
  endfunction

  function automatic logic signed [34:0] floor_q(input logic neg, input logic [32:0] quo,
                                                 input logic [31:0] rem);
    logic signed [34:0] m;
    m = $signed({2'b00, quo});
    if (neg) m = -(m + ((rem != 32'd0) ? 35'sd1 : 35'sd0));
    return m;
  endfunction

  assign lx = $signed({pos_x[31], pos_x}) - $signed({cfg.origin_x[31], cfg.origin_x});
  assign ly = $signed({pos_y[31], pos_y}) - $signed({cfg.origin_y[31], cfg.origin_y});
  assign stepx = div_step(remx, quox, ds);
  assign stepy = div_step(remy, quoy, ds);
  assign fx = floor_q(negx, quox, remx);
  assign fy = floor_q(negy, quoy, remy);

  // Coordinates far outside the grid are pinned just beyond its reach.
  always_comb begin
    if (fx < -35'sd2) col_c = -CW'(2);
    else if (fx > 35'(MAX_COLS + 1)) col_c = CW'(MAX_COLS + 1);
    else col_c = CW'(fx);
    if (fy < -35'sd2) row_c = -RW'(2);
    else if (fy > 35'(MAX_ROWS + 1)) row_c = RW'(MAX_ROWS + 1);
    else row_c = RW'(fy);
  end

  assign busy   = (state != F_IDLE);
  assign q_push = (state == F_PUSH) && !q_full && (req != REQ_NONE);
  assign q_data = {req, id, col_c, row_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state <= (req_type == REQ_INSERT || req_type == REQ_QUERY) ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          if (cnt == 6'd32) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full || req == REQ_NONE) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && accept) begin
      req  <= req_type;
      id   <= ball_id;
      ds   <= (cfg.cell_size == 31'd0) ? 31'd1 : cfg.cell_size;
      negx <= lx[32];
      negy <= ly[32];
      quox <= lx[32] ? 33'(-lx) : 33'(lx);
      quoy <= ly[32] ? 33'(-ly) : 33'(ly);
      remx <= 32'd0;
      remy <= 32'd0;
      cnt  <= 6'd0;
    end else if (state == F_DIV) begin
      {remx, quox} <= stepx;
      {remy, quoy} <= stepy;
      cnt <= cnt + 6'd1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ugcbp_back.sv
// Back end: owns the bucket count and bucket entry memories, runs inserts,
// neighbor walks and clearing sweeps, and drives the result strobe. Uses ugcbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ugcbp_back
  import ugcbp_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  parameter int BUCKET_DEPTH = 4,
  parameter int CW = 8,
  parameter int RW = 8,
  parameter int QW = 2 + 10 + CW + RW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire logic [QW-1:0] q_data,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               init_busy,
  output logic               strobe,
  output logic [2:0]         status,
  output logic [9:0]         candidate_id,
  output logic               last
);

  localparam int NCELLS = MAX_COLS * MAX_ROWS;
  localparam int CAW = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int NENT = NCELLS * BUCKET_DEPTH;
  localparam int EAW = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int NW = $clog2(BUCKET_DEPTH + 1);

  typedef enum logic [7:0] {
    B_CLR    = 8'b00000001,
    B_IDLE   = 8'b00000010,
    B_INS_WR = 8'b00000100,
    B_Q_CELL = 8'b00001000,
    B_Q_CNT  = 8'b00010000,
    B_Q_ENT  = 8'b00100000,
    B_Q_END  = 8'b01000000
  } bstate_t;

  bstate_t state;
  logic    init;
  logic [CAW-1:0] clr_addr;
  logic [9:0]     id;
  logic signed [CW-1:0] col;
  logic signed [RW-1:0] row;
  logic [1:0]     qr, qc;
  logic [NW-1:0]  e, n;
  logic [CAW-1:0] cur_cell;
  logic           pend_valid;
  logic [9:0]     pend_id;

  logic [NW-1:0]  cnt_mem [NCELLS];
  logic [9:0]     ent_mem [NENT];
  logic [NW-1:0]  cnt_q;
  logic [9:0]     ent_q;
  logic [CAW-1:0] cnt_raddr, cnt_waddr;
  logic [NW-1:0]  cnt_wdata;
  logic           cnt_we, ent_we;
  logic [EAW-1:0] ent_raddr, ent_waddr;

  logic [1:0]           h_req;
  logic [9:0]           h_id;
  logic signed [CW-1:0] h_col;
  logic signed [RW-1:0] h_row;
  logic signed [13:0]   ar, ac;
  logic [10:0]          cols_u, rows_u;
  logic                 in_grid;
  logic [CAW-1:0]       cell_c;
  logic                 last_cell;

  logic          emit;
  logic [2:0]    emit_st;
  logic [9:0]    emit_id;
  logic          emit_last;

  assign {h_req, h_id, h_col, h_row} = q_data;
  assign cols_u = (11'(cfg.grid_cols) > 11'(MAX_COLS)) ? 11'(MAX_COLS) : 11'(cfg.grid_cols);
  assign rows_u = (11'(cfg.grid_rows) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(cfg.grid_rows);
  assign last_cell = (qr == 2'd2) && (qc == 2'd2);
  assign init_busy = init;

  // Cell under examination: the popped request's own cell, or a neighbor during a walk.
  always_comb begin
    if (state == B_IDLE) begin
      ar = 14'(h_row);
      ac = 14'(h_col);
    end else begin
      ar = 14'(row) + $signed({12'd0, qr}) - 14'sd1;
      ac = 14'(col) + $signed({12'd0, qc}) - 14'sd1;
    end
    in_grid = (ar >= 14'sd0) && (ar < $signed({3'b000, rows_u})) &&
              (ac >= 14'sd0) && (ac < $signed({3'b000, cols_u}));
    cell_c = CAW'(32'(ar) * MAX_COLS + 32'(ac));
  end

  always_comb begin
    q_pop     = (state == B_IDLE) && !q_empty;
    cnt_raddr = cell_c;
    ent_raddr = EAW'(32'(cur_cell) * BUCKET_DEPTH);
    cnt_we    = 1'b0;
    cnt_waddr = cur_cell;
    cnt_wdata = NW'(cnt_q + NW'(1));
    ent_we    = 1'b0;
    ent_waddr = EAW'(32'(cur_cell) * BUCKET_DEPTH + 32'(cnt_q));
    emit      = 1'b0;
    emit_st   = ST_NONE;
    emit_id   = 10'd0;
    emit_last = 1'b1;
    unique case (state)
      B_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
        cnt_wdata = '0;
        if (32'(clr_addr) == NCELLS - 1 && !init) begin
          emit    = 1'b1;
          emit_st = ST_CLEARED;
        end
      end
      B_IDLE: begin
        if (!q_empty && h_req == REQ_INSERT && !in_grid) begin
          emit    = 1'b1;
          emit_st = ST_OUTSIDE;
        end
      end
      B_INS_WR: begin
        emit = 1'b1;
        if (32'(cnt_q) >= BUCKET_DEPTH) begin
          emit_st = ST_FULL;
        end else begin
          emit_st = ST_INSERTED;
          cnt_we  = 1'b1;
          ent_we  = 1'b1;
        end
      end
      B_Q_CELL: ;
      B_Q_CNT: ;
      B_Q_ENT: begin
        ent_raddr = EAW'(32'(cur_cell) * BUCKET_DEPTH + 32'(e) + 1);
        // A candidate is held back one step so the final one can carry last.
        if (ent_q != id && pend_valid) begin
          emit      = 1'b1;
          emit_st   = ST_CANDIDATE;
          emit_id   = pend_id;
          emit_last = 1'b0;
        end
      end
      B_Q_END: begin
        emit    = 1'b1;
        emit_st = pend_valid ? ST_CANDIDATE : ST_NONE;
        emit_id = pend_valid ? pend_id : 10'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_q <= cnt_mem[cnt_raddr];
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
  end

  always_ff @(posedge clk) begin
    ent_q <= ent_mem[ent_raddr];
    if (ent_we) ent_mem[ent_waddr] <= id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLR;
      init       <= 1'b1;
      clr_addr   <= '0;
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      strobe <= emit;
      unique case (state)
        B_CLR: begin
          clr_addr <= clr_addr + CAW'(1);
          if (32'(clr_addr) == NCELLS - 1) begin
            state <= B_IDLE;
            init  <= 1'b0;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            id       <= h_id;
            col      <= h_col;
            row      <= h_row;
            cur_cell <= cell_c;
            qr       <= 2'd0;
            qc       <= 2'd0;
            pend_valid <= 1'b0;
            case (h_req)
              REQ_INSERT: state <= in_grid ? B_INS_WR : B_IDLE;
              REQ_QUERY:  state <= B_Q_CELL;
              default: begin
                clr_addr <= '0;
                state    <= B_CLR;
              end
            endcase
          end
        end
        B_INS_WR: state <= B_IDLE;
        B_Q_CELL: begin
          if (in_grid) begin
            cur_cell <= cell_c;
            state    <= B_Q_CNT;
          end else if (last_cell) begin
            state <= B_Q_END;
          end else begin
            qc <= (qc == 2'd2) ? 2'd0 : qc + 2'd1;
            qr <= (qc == 2'd2) ? qr + 2'd1 : qr;
          end
        end
        B_Q_CNT: begin
          e <= '0;
          n <= (32'(cnt_q) > BUCKET_DEPTH) ? NW'(BUCKET_DEPTH) : cnt_q;
          if (cnt_q != '0) begin
            state <= B_Q_ENT;
          end else if (last_cell) begin
            state <= B_Q_END;
          end else begin
            qc <= (qc == 2'd2) ? 2'd0 : qc + 2'd1;
            qr <= (qc == 2'd2) ? qr + 2'd1 : qr;
            state <= B_Q_CELL;
          end
        end
        B_Q_ENT: begin
          if (ent_q != id) begin
            pend_valid <= 1'b1;
            pend_id    <= ent_q;
          end
          if (NW'(e + NW'(1)) < n) begin
            e <= e + NW'(1);
          end else if (last_cell) begin
            state <= B_Q_END;
          end else begin
            qc <= (qc == 2'd2) ? 2'd0 : qc + 2'd1;
            qr <= (qc == 2'd2) ? qr + 2'd1 : qr;
            state <= B_Q_CELL;
          end
        end
        B_Q_END: state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    status       <= emit_st;
    candidate_id <= emit_id;
    last         <= emit_last;
  end

endmodule
`default_nettype wire

// File: rtl/uniform_grid_collision_broad_phase_core.sv
// Top level of the uniform grid broad phase: configuration registers, front end,
// request queue and back end. Uses ugcbp_pkg, ugcbp_front, ugcbp_fifo, ugcbp_back.
//
//  channel  | handshake             | payload
//  command  | start / busy          | req_type, ball_id, pos_x, pos_y
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//  result   | strobe (no backpressure) | status, candidate_id, last
//
// On an insert or query the front end loads the request, runs 33 divider steps of the
// bit-serial floor division and transfers the result into the queue; a clear goes
// straight to the transfer. The back end writes an insert inside the grid in B_INS_WR
// and answers one outside the grid from B_IDLE; a query walks the nine neighbor cells
// through B_Q_CELL, B_Q_CNT and B_Q_ENT and ends in B_Q_END; a clear sweeps the
// count memory over every cell. After reset the same sweep runs with busy held high.
// Results leave one per strobe cycle; the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none
module uniform_grid_collision_broad_phase_core
  import ugcbp_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  parameter int BUCKET_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         req_type,
  input  wire logic [9:0]         ball_id,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    strobe,
  output logic [2:0]              status,
  output logic [9:0]              candidate_id,
  output logic                    last
);

  localparam int CW = $clog2(MAX_COLS + 2) + 1;
  localparam int RW = $clog2(MAX_ROWS + 2) + 1;
  localparam int QW = 2 + 10 + CW + RW;

  cfg_t          cfg;
  logic          front_busy, init_busy;
  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;
  logic          accept;

  assign cfg_ready = 1'b1;
  assign busy      = front_busy || init_busy;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_size <= 31'd65536;
      cfg.origin_x  <= 32'd0;
      cfg.origin_y  <= 32'd0;
      cfg.grid_cols <= 7'd64;
      cfg.grid_rows <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CELL_SIZE: cfg.cell_size <= cfg_data[30:0];
        CFG_ORIGIN_X:  cfg.origin_x  <= cfg_data;
        CFG_ORIGIN_Y:  cfg.origin_y  <= cfg_data;
        CFG_GRID_COLS: cfg.grid_cols <= cfg_data[6:0];
        CFG_GRID_ROWS: cfg.grid_rows <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  ugcbp_front #(
    .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .CW(CW), .RW(RW), .QW(QW)
  ) u_front (
    .clk(clk), .rst(rst), .accept(accept), .req_type(req_type), .ball_id(ball_id),
    .pos_x(pos_x), .pos_y(pos_y), .cfg(cfg), .busy(front_busy),
    .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
  );

  ugcbp_fifo #(.WIDTH(QW)) u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  ugcbp_back #(
    .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .BUCKET_DEPTH(BUCKET_DEPTH),
    .CW(CW), .RW(RW), .QW(QW)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_data(q_rdata), .q_empty(q_empty),
    .q_pop(q_pop), .init_busy(init_busy), .strobe(strobe), .status(status),
    .candidate_id(candidate_id), .last(last)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("busy not raised after a command transfer");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_CANDIDATE |-> last)
    else $error("non-candidate result without last");

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_CANDIDATE |-> candidate_id == 10'd0)
    else $error("candidate id set on a non-candidate result");

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for uniform_grid_collision_broad_phase_core.
// Depends on ugcbp_pkg and the core RTL; a built-in grid model predicts every result.
`timescale 1ns / 1ps
module testbench;
  import ugcbp_pkg::*;

  localparam int NCOLS = 64;
  localparam int NROWS = 64;
  localparam int DEPTH = 4;
  localparam int STALL_LIMIT = 30000;
  localparam int DRAIN_CYCLES = 4300;

  typedef struct {
    logic [1:0]  req;
    logic [9:0]  id;
    logic [31:0] px;
    logic [31:0] py;
  } grid_req_t;

  typedef struct {
    logic [2:0] status;
    logic [9:0] id;
    logic       last;
  } grid_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] req_type = REQ_INSERT;
  logic [9:0] ball_id = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = CFG_CELL_SIZE;
  logic [31:0] cfg_data = '0;
  logic busy, cfg_ready, strobe, last;
  logic [2:0] status;
  logic [9:0] candidate_id;

  uniform_grid_collision_broad_phase_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .ball_id(ball_id), .pos_x(pos_x), .pos_y(pos_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .strobe(strobe), .status(status),
    .candidate_id(candidate_id), .last(last)
  );

  always #5 clk = ~clk;

  // Model copy of the registers and the grid contents.
  logic [30:0] m_cell_size = 31'd65536;
  logic [31:0] m_origin_x = '0;
  logic [31:0] m_origin_y = '0;
  logic [6:0]  m_cols = 7'd64;
  logic [6:0]  m_rows = 7'd64;
  int unsigned cell_fill [NCOLS*NROWS];
  logic [9:0]  cell_ids [NCOLS*NROWS*DEPTH];

  grid_req_t pending_reqs[$];
  grid_res_t expected_results[$];
  grid_req_t cur_req;
  int unsigned sender_idle_pct = 0;
  int errors = 0;
  int reqs_accepted = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int stall_count = 0;

  initial begin
    foreach (cell_fill[i]) cell_fill[i] = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic longint floor_coord(input logic [31:0] pos, input logic [31:0] org);
    longint local_off, cs, q;
    local_off = longint'(signed'(pos)) - longint'(signed'(org));
    cs = (m_cell_size == 0) ? 1 : longint'(m_cell_size);
    q = local_off / cs;
    if ((local_off % cs) != 0 && local_off < 0) q--;
    return q;
  endfunction

  function automatic void push_result(input logic [2:0] st, input logic [9:0] id,
                                      input logic lst);
    grid_res_t r;
    r.status = st;
    r.id = id;
    r.last = lst;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Applies one accepted request to the grid model and queues its results.
  function automatic void predict_grid(input grid_req_t it);
    longint cols, rows, col, row, r, c;
    int unsigned addr, n;
    int found;
    cols = (m_cols > NCOLS) ? NCOLS : m_cols;
    rows = (m_rows > NROWS) ? NROWS : m_rows;
    found = 0;
    if (it.req == REQ_CLEAR) begin
      foreach (cell_fill[i]) cell_fill[i] = 0;
      push_result(ST_CLEARED, '0, 1'b1);
      return;
    end
    if (it.req == REQ_NONE) return;
    col = floor_coord(it.px, m_origin_x);
    row = floor_coord(it.py, m_origin_y);
    if (it.req == REQ_INSERT) begin
      if (col < 0 || col >= cols || row < 0 || row >= rows) begin
        push_result(ST_OUTSIDE, '0, 1'b1);
      end else begin
        addr = 32'(row * NCOLS + col);
        n = cell_fill[addr];
        if (n >= DEPTH) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          cell_ids[addr*DEPTH + n] = it.id;
          cell_fill[addr] = n + 1;
          push_result(ST_INSERTED, '0, 1'b1);
        end
      end
      return;
    end
    for (r = row - 1; r <= row + 1; r++) begin
      if (r < 0 || r >= rows) continue;
      for (c = col - 1; c <= col + 1; c++) begin
        if (c < 0 || c >= cols) continue;
        addr = 32'(r * NCOLS + c);
        for (int e = 0; e < cell_fill[addr]; e++) begin
          if (cell_ids[addr*DEPTH + e] != it.id) begin
            push_result(ST_CANDIDATE, cell_ids[addr*DEPTH + e], 1'b0);
            found++;
          end
        end
      end
    end
    if (found == 0) push_result(ST_NONE, '0, 1'b1);
    else expected_results[$].last = 1'b1;
  endfunction

  // Command driver: holds start until the transfer, then loads the next request.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_grid(cur_req);
        reqs_accepted++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          start <= 1'b1;
          req_type <= cur_req.req;
          ball_id <= cur_req.id;
          pos_x <= cur_req.px;
          pos_y <= cur_req.py;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk) begin
    grid_res_t exp_r;
    if (!rst) begin
      if (strobe) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d id=%0d last=%0b",
                                    status, candidate_id, last));
        end else begin
          exp_r = expected_results.pop_front();
          results_checked++;
          if (status !== exp_r.status)
            report_mismatch($sformatf("status %0d, want %0d", status, exp_r.status));
          if (candidate_id !== exp_r.id)
            report_mismatch($sformatf("candidate_id %0d, want %0d", candidate_id, exp_r.id));
          if (last !== exp_r.last)
            report_mismatch($sformatf("last %0b, want %0b", last, exp_r.last));
        end
      end
      if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_CELL_SIZE: m_cell_size = value[30:0];
      CFG_ORIGIN_X:  m_origin_x = value;
      CFG_ORIGIN_Y:  m_origin_y = value;
      CFG_GRID_COLS: m_cols = value[6:0];
      CFG_GRID_ROWS: m_rows = value[6:0];
      default: ;
    endcase
  endtask

  task automatic add_req(input logic [1:0] rq, input logic [9:0] id,
                         input logic [31:0] px, input logic [31:0] py);
    grid_req_t it;
    it.req = rq;
    it.id = id;
    it.px = px;
    it.py = py;
    pending_reqs.insert(pending_reqs.size(), it);
  endtask

  // Position inside the given cell of the current grid, with a random fraction.
  function automatic logic [31:0] pos_in_cell(input longint cidx, input logic [31:0] org);
    longint cs;
    cs = (m_cell_size == 0) ? 1 : longint'(m_cell_size);
    return 32'(longint'(signed'(org)) + cidx * cs + longint'($urandom_range(32'(cs - 1))));
  endfunction

  // Random requests: mostly inserts and queries clustered on a few cells.
  task automatic add_random_reqs(input int count);
    int sel, span_c, span_r;
    logic [9:0] id;
    logic [1:0] rq;
    span_c = (m_cols == 0) ? 2 : ((m_cols > NCOLS) ? NCOLS : m_cols);
    span_r = (m_rows == 0) ? 2 : ((m_rows > NROWS) ? NROWS : m_rows);
    if (span_c > 5) span_c = 5;
    if (span_r > 5) span_r = 5;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 3) begin
        add_req(REQ_CLEAR, 10'($urandom), $urandom, $urandom);
      end else if (sel < 7) begin
        add_req(REQ_NONE, 10'($urandom), $urandom, $urandom);
        k--;
      end else if (sel < 17) begin
        add_req(2'($urandom_range(1)), 10'($urandom), $urandom, $urandom);
      end else begin
        rq = ($urandom_range(99) < 55) ? REQ_INSERT : REQ_QUERY;
        id = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(15));
        add_req(rq, id,
                pos_in_cell(longint'($urandom_range(span_c + 1)) - 1, m_origin_x),
                pos_in_cell(longint'($urandom_range(span_r + 1)) - 1, m_origin_y));
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || start || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  localparam logic [31:0] ONE = 32'h0001_0000;

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Default grid: 64 x 64 cells of size 1.0 at the origin.
    sender_idle_pct = 0;
    add_req(REQ_QUERY, 10'd1, 32'h0000_8000, 32'h0000_8000);
    add_req(REQ_INSERT, 10'd5, 32'h0000_0000, 32'h0000_0000);
    add_req(REQ_INSERT, 10'd6, 32'h0001_8000, 32'h0000_8000);
    add_req(REQ_INSERT, 10'd5, 32'h0000_4000, 32'h0000_c000);
    add_req(REQ_INSERT, 10'd1023, 32'h0000_ffff, 32'h0000_ffff);
    add_req(REQ_INSERT, 10'd0, 32'h0000_0001, 32'h0000_0002);
    add_req(REQ_INSERT, 10'd7, 32'h0000_1000, 32'h0000_1000);
    add_req(REQ_INSERT, 10'd9, 32'hffff_8000, 32'h0000_0000);
    add_req(REQ_INSERT, 10'd9, 32'h0040_0000, 32'h0000_0000);
    add_req(REQ_INSERT, 10'd8, 32'h003f_ffff, 32'h003f_ffff);
    add_req(REQ_INSERT, 10'd2, 32'h8000_0000, 32'h7fff_ffff);
    add_req(REQ_INSERT, 10'd2, 32'h7fff_ffff, 32'h8000_0000);
    add_req(REQ_QUERY, 10'd5, 32'h0000_8000, 32'h0000_8000);
    add_req(REQ_QUERY, 10'd1023, 32'h0001_8000, 32'h0001_8000);
    add_req(REQ_QUERY, 10'd3, 32'h003f_8000, 32'h003f_8000);
    add_req(REQ_QUERY, 10'd3, 32'h001e_0000, 32'h001e_0000);
    add_req(REQ_QUERY, 10'd3, 32'hffff_8000, 32'h0000_8000);
    add_req(REQ_QUERY, 10'd3, 32'hfffe_8000, 32'h0000_8000);
    add_req(REQ_QUERY, 10'd3, 32'h8000_0000, 32'h8000_0000);
    add_req(REQ_NONE, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff);
    add_req(REQ_CLEAR, 10'd0, 32'h0, 32'h0);
    add_req(REQ_QUERY, 10'd3, 32'h0000_8000, 32'h0000_8000);
    add_random_reqs(30);
    wait_drained();

    // Zero cell size, extreme origins, oversized columns, no rows.
    sender_idle_pct = 68;
    write_reg(CFG_CELL_SIZE, 32'h0);
    write_reg(CFG_ORIGIN_X, 32'h8000_0000);
    write_reg(CFG_ORIGIN_Y, 32'h7fff_ffff);
    write_reg(CFG_GRID_COLS, 32'hffff_ffff);
    write_reg(CFG_GRID_ROWS, 32'h0);
    add_random_reqs(15);
    wait_drained();

    // Largest cell size on a single cell.
    sender_idle_pct = 20;
    write_reg(CFG_CELL_SIZE, 32'hffff_ffff);
    write_reg(CFG_ORIGIN_X, 32'h0);
    write_reg(CFG_ORIGIN_Y, 32'h0);
    write_reg(CFG_GRID_COLS, 32'd1);
    write_reg(CFG_GRID_ROWS, 32'd1);
    add_random_reqs(20);
    wait_drained();

    // Half-unit cells on a small grid with a whole-unit X origin and a fractional Y origin.
    sender_idle_pct = 0;
    write_reg(CFG_CELL_SIZE, 32'h0000_8000);
    write_reg(CFG_ORIGIN_X, 32'hfffd_0000);
    write_reg(CFG_ORIGIN_Y, 32'h0005_4000);
    write_reg(CFG_GRID_COLS, 32'd6);
    write_reg(CFG_GRID_ROWS, 32'd5);
    add_random_reqs(25);
    wait_drained();

    // Narrow the grid to two columns without a clear so that stored entries fall outside.
    sender_idle_pct = 68;
    write_reg(CFG_GRID_COLS, 32'd2);
    write_reg(CFG_GRID_ROWS, 32'd64);
    add_random_reqs(20);
    wait_drained();

    // Odd cell size and a random origin near zero.
    sender_idle_pct = 20;
    write_reg(CFG_CELL_SIZE, 3 * ONE + 32'd123);
    write_reg(CFG_ORIGIN_X, 32'($urandom_range(65535)) - ONE);
    write_reg(CFG_ORIGIN_Y, 32'($urandom_range(65535)));
    write_reg(CFG_GRID_COLS, 32'd64);
    write_reg(CFG_GRID_ROWS, 32'd3);
    add_random_reqs(30);
    wait_drained();

    $display("covered %0d requests, %0d results, %0d register writes over six settings",
             reqs_accepted, results_checked, cfg_writes);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
